// File: hw/rtl/crcrp_pkg.sv
// Shared types, constants and the CRC-32 byte update for the record chain parser.
// No dependencies; imported by every other file of the block.
package crcrp_pkg;

  localparam int APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_DEVICE_SIZE = 2'd0;
  localparam logic [31:0] DEVICE_SIZE_RESET = 32'd256;

  localparam logic [7:0]  FLAG_BYTE    = 8'hC1;
  localparam logic [31:0] HEADER_BYTES = 32'd12;
  localparam logic [31:0] MAX_DATA_LEN = 32'hFFFF0000;
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

  // header byte positions relative to the record start
  localparam logic [31:0] POS_FLAG      = 32'd0;
  localparam logic [31:0] POS_CRC_FIRST = 32'd4;
  localparam logic [31:0] POS_LEN_FIRST = 32'd8;
  localparam logic [31:0] POS_LEN_LAST  = 32'd11;

  // end_reason codes
  localparam logic [2:0] END_NO_ROOM  = 3'd0;
  localparam logic [2:0] END_NO_FLAG  = 3'd1;
  localparam logic [2:0] END_LEN_BIG  = 3'd2;
  localparam logic [2:0] END_OVERRUN  = 3'd3;
  localparam logic [2:0] END_CRC_BAD  = 3'd4;
  localparam logic [2:0] END_EMPTY    = 3'd5;

  localparam int TDATA_W = 192;

  typedef struct packed {
    logic       first_byte;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        record_valid;
    logic        chain_done;
    logic [23:0] record_tag;
    logic [31:0] data_length;
    logic [31:0] record_offset;
    logic [31:0] record_bytes;
    logic [2:0]  end_reason;
    logic        chain_complete;
    logic [31:0] record_count;
    logic [31:0] total_bytes;
  } result_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/crcrp_in_reg.sv
// Input register of the record chain parser: holds one item ahead of the parse logic.
// Depends on crcrp_pkg.
module crcrp_in_reg
  import crcrp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_valid,
  output logic     s_ready,
  input  in_item_t s_item,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  logic item_valid_next;

  assign s_ready = !item_valid || advance;

  always_comb begin
    item_valid_next = item_valid;
    if (s_valid && s_ready) begin
      item_valid_next = 1'b1;
    end else if (advance) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

// File: hw/rtl/crcrp_core.sv
// Parse state and per-byte decisions: header capture, CRC update, bound checks.
// Depends on crcrp_pkg.
module crcrp_core
  import crcrp_pkg::*;
#(
  parameter int RECORD_ALIGN = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] device_size,
  input  logic        fire,
  input  in_item_t    item,
  output logic        has_result,
  output result_t     result
);

  localparam int MW = (RECORD_ALIGN > 1) ? $clog2(RECORD_ALIGN) : 1;
  localparam logic [MW:0] ALIGN_V = (MW+1)'(RECORD_ALIGN);

  // payload length mod RECORD_ALIGN, one bit at a time
  function automatic logic [MW-1:0] mod_step(input logic [MW-1:0] m_in, input logic [7:0] b);
    logic [MW-1:0] m;
    logic [MW:0]   t;
    m = m_in;
    for (int i = 7; i >= 0; i--) begin
      t = {m, b[i]};
      if (t >= ALIGN_V) begin
        t = t - ALIGN_V;
      end
      m = t[MW-1:0];
    end
    return m;
  endfunction

  // state
  logic [31:0]   rel;
  logic [31:0]   start;
  logic [31:0]   crc;
  logic [31:0]   count;
  logic          finished;
  logic [31:0]   stored_crc;
  logic [23:0]   tag;
  logic [31:0]   plen;
  logic [MW-1:0] len_mod;
  logic [31:0]   rec_bytes;
  logic [31:0]   next_start;

  logic [31:0]   rel_next;
  logic [31:0]   start_next;
  logic [31:0]   crc_next;
  logic [31:0]   count_next;
  logic          finished_next;

  // per-byte terms
  logic [7:0]    b;
  logic          first;
  logic [31:0]   cur_rel;
  logic [31:0]   cur_start;
  logic [31:0]   cur_crc;
  logic [31:0]   cur_count;
  logic [31:0]   rel_inc;
  logic          in_crc_field;
  logic [31:0]   crc_new;
  logic [31:0]   len_full;
  logic [MW-1:0] m_in;
  logic [MW-1:0] m_new;
  logic [MW:0]   pad;
  logic [32:0]   sum_a;
  logic [32:0]   sum_b;
  logic [32:0]   sum_tail;
  logic [32:0]   dev33;
  logic          at_len_last;
  logic          rec_end;
  logic          crc_ok;
  logic          done_after;

  assign b     = item.data_byte;
  assign first = item.first_byte;

  assign cur_rel   = first ? 32'd0 : rel;
  assign cur_start = first ? 32'd0 : start;
  assign cur_crc   = first ? CRC_INIT : crc;
  assign cur_count = first ? 32'd0 : count;
  assign rel_inc   = cur_rel + 32'd1;

  assign in_crc_field = (cur_rel >= POS_CRC_FIRST) && (cur_rel < POS_LEN_FIRST);
  assign crc_new      = crc_byte(cur_crc, in_crc_field ? 8'd0 : b);

  assign len_full = {plen[23:0], b};
  assign m_in     = (cur_rel == POS_LEN_FIRST) ? '0 : len_mod;
  assign m_new    = mod_step(m_in, b);
  assign pad      = (m_new == '0) ? '0 : (ALIGN_V - {1'b0, m_new});

  // record end and room for a following header, formed without wrap
  assign dev33    = {1'b0, device_size};
  assign sum_a    = {1'b0, cur_start} + {1'b0, len_full} + 33'(pad) + 33'(HEADER_BYTES);
  assign sum_b    = {1'b0, cur_start} + {1'b0, len_full} + 33'(pad) + 33'(2 * HEADER_BYTES);
  assign sum_tail = {1'b0, next_start} + 33'(HEADER_BYTES);

  assign at_len_last = (cur_rel == POS_LEN_LAST);
  // a zero-length record ends on its last header byte
  assign rec_end    = at_len_last ? (len_full == 32'd0)
                                  : ((cur_rel > POS_LEN_LAST) && (rel_inc == rec_bytes));
  assign crc_ok     = ((crc_new ^ CRC_INIT) == stored_crc);
  assign done_after = at_len_last ? (sum_b > dev33) : (sum_tail > dev33);

  always_comb begin
    has_result    = 1'b0;
    result        = '0;
    rel_next      = rel;
    start_next    = start;
    crc_next      = crc;
    count_next    = count;
    finished_next = finished;

    if (fire && (first || !finished)) begin
      rel_next      = rel_inc;
      start_next    = cur_start;
      crc_next      = crc_new;
      count_next    = cur_count;
      finished_next = 1'b0;
      result.chain_complete = 1'b1;
      result.record_count   = cur_count;
      result.total_bytes    = cur_start;

      if (first && (device_size < HEADER_BYTES)) begin
        rel_next          = 32'd0;
        crc_next          = CRC_INIT;
        finished_next     = 1'b1;
        has_result        = 1'b1;
        result.chain_done = 1'b1;
        result.end_reason = (device_size == 32'd0) ? END_EMPTY : END_NO_ROOM;
      end else if (cur_rel == POS_FLAG) begin
        if (b != FLAG_BYTE) begin
          finished_next     = 1'b1;
          has_result        = 1'b1;
          result.chain_done = 1'b1;
          result.end_reason = END_NO_FLAG;
        end
      end else if (at_len_last && (len_full > MAX_DATA_LEN)) begin
        finished_next     = 1'b1;
        has_result        = 1'b1;
        result.chain_done = 1'b1;
        result.end_reason = END_LEN_BIG;
      end else if (at_len_last && (sum_a > dev33)) begin
        finished_next         = 1'b1;
        has_result            = 1'b1;
        result.chain_done     = 1'b1;
        result.end_reason     = END_OVERRUN;
        result.chain_complete = 1'b0;
      end else if (rec_end) begin
        has_result = 1'b1;
        if (!crc_ok) begin
          finished_next     = 1'b1;
          result.chain_done = 1'b1;
          result.end_reason = END_CRC_BAD;
        end else begin
          rel_next             = 32'd0;
          crc_next             = CRC_INIT;
          start_next           = at_len_last ? sum_a[31:0] : next_start;
          count_next           = cur_count + 32'd1;
          finished_next        = done_after;
          result.record_valid  = 1'b1;
          result.chain_done    = done_after;
          result.end_reason    = END_NO_ROOM;
          result.record_tag    = tag;
          result.data_length   = at_len_last ? len_full : plen;
          result.record_offset = cur_start;
          result.record_bytes  = at_len_last ? HEADER_BYTES : rec_bytes;
          result.record_count  = cur_count + 32'd1;
          result.total_bytes   = at_len_last ? sum_a[31:0] : next_start;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rel      <= 32'd0;
      start    <= 32'd0;
      crc      <= CRC_INIT;
      count    <= 32'd0;
      finished <= 1'b1;
    end else begin
      rel      <= rel_next;
      start    <= start_next;
      crc      <= crc_next;
      count    <= count_next;
      finished <= finished_next;
    end
  end

  // header fields shift in as their bytes pass
  always_ff @(posedge clk) begin
    if (fire && (first || !finished)) begin
      if ((cur_rel >= 32'd1) && (cur_rel < POS_CRC_FIRST)) begin
        tag <= {tag[15:0], b};
      end
      if (in_crc_field) begin
        stored_crc <= {stored_crc[23:0], b};
      end
      if ((cur_rel >= POS_LEN_FIRST) && (cur_rel <= POS_LEN_LAST)) begin
        plen    <= len_full;
        len_mod <= m_new;
      end
      if (at_len_last) begin
        rec_bytes  <= len_full + 32'(pad) + HEADER_BYTES;
        next_start <= sum_a[31:0];
      end
    end
  end

endmodule

// File: hw/rtl/crcrp_out_reg.sv
// Result register of the record chain parser; loads whenever it is empty or being drained.
// Depends on crcrp_pkg.
module crcrp_out_reg
  import crcrp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  logic    has_result,
  input  result_t result,
  input  logic    m_ready,
  output logic    m_valid,
  output result_t m_result,
  output logic    advance
);

  assign advance = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && has_result) begin
      m_result <= result;
    end
  end

endmodule

// File: hw/rtl/crc_checked_record_chain_parser.sv
// Top level of the CRC-32 checked record chain parser: APB register, stream ports.
// Depends on crcrp_pkg, crcrp_in_reg, crcrp_core, crcrp_out_reg.
//
//   channel   role       fields
//   s_*       in item    tdata: data_byte[7:0]; tuser: first_byte
//   m_*       result     tdata: tag, length, offset, bytes, reason, complete, count, total
//                        tlast: chain_done; tuser: record_valid
//   APB       config     device_size_bytes at byte address 0
//
// One item per cycle while the result register is not stalled; an accepted item passes
// the input register, then one pass of parse logic and CRC update, into the result register.
// The parse state loop (relative offset, CRC, record start) is held in core registers and fed back.
// Synchronous active-high reset; no clearing pass. The chain waits for a first byte.
// A stalled result register holds the parse logic; the input register still fills.
module crc_checked_record_chain_parser
  import crcrp_pkg::*;
#(
  parameter int RECORD_ALIGN = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // data_byte[7:0]
  input  logic                  s_tuser,   // first_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // record_tag[23:0], data_length[55:24], record_offset[87:56], record_bytes[119:88],
  // end_reason[122:120], chain_complete[123], record_count[155:124],
  // total_bytes[187:156], zero[191:188]
  output logic [TDATA_W-1:0]    m_tdata,
  output logic                  m_tlast,   // chain_done
  output logic                  m_tuser,   // record_valid
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [31:0] device_size;
  logic        advance;
  logic        item_valid;
  in_item_t    s_item;
  in_item_t    item;
  logic        fire;
  logic        has_result;
  result_t     result;
  result_t     m_result;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_DEVICE_SIZE) ? device_size : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_size <= DEVICE_SIZE_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_DEVICE_SIZE)) begin
      device_size <= pwdata;
    end
  end

  assign s_item.data_byte  = s_tdata;
  assign s_item.first_byte = s_tuser;
  assign fire = item_valid && advance;

  crcrp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  crcrp_core #(
    .RECORD_ALIGN (RECORD_ALIGN)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .device_size (device_size),
    .fire        (fire),
    .item        (item),
    .has_result  (has_result),
    .result      (result)
  );

  crcrp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .has_result (has_result),
    .result     (result),
    .m_ready    (m_tready),
    .m_valid    (m_tvalid),
    .m_result   (m_result),
    .advance    (advance)
  );

  assign m_tuser = m_result.record_valid;
  assign m_tlast = m_result.chain_done;
  assign m_tdata = {4'd0,
                    m_result.total_bytes,
                    m_result.record_count,
                    m_result.chain_complete,
                    m_result.end_reason,
                    m_result.record_bytes,
                    m_result.record_offset,
                    m_result.data_length,
                    m_result.record_tag};

  // every result either carries a record or ends the chain
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser || m_tlast))
    else $error("result with neither record nor chain end");

  // a held result is never overwritten by the parse logic
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !fire)
    else $error("parse step while result stalled");

  // incomplete marking only on a chain end by overrun
  a_incomplete: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_result.chain_complete) |->
      (m_tlast && (m_result.end_reason == END_OVERRUN)))
    else $error("incomplete chain without overrun end");

  // an accepted record can only end the chain for lack of room
  a_record_reason: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_result.end_reason == END_NO_ROOM))
    else $error("record result with a failure reason");

endmodule

// File: test/record_chain_checker.sv
// Checker for the record chain parser: predicts each report from the accepted bytes
// and compares it with the result channel. Depends on crcrp_pkg only.
`timescale 1ns / 100ps

module record_chain_checker
  import crcrp_pkg::*;
#(
  parameter int ALIGN = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [TDATA_W-1:0]    m_tdata,
  input  logic                  m_tlast,
  input  logic                  m_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic [31:0]           prdata,
  input  logic                  pready,
  output int                    failures,
  output int                    outstanding,
  output int                    records_seen,
  output int                    chain_ends
);

  // parser state as the block should hold it
  logic [31:0] dev_size;
  logic [31:0] cur_addr;
  logic [31:0] rec_base;
  logic [31:0] crc_acc;
  logic [31:0] crc_stored;
  logic [23:0] rec_tag;
  logic [31:0] rec_len;
  logic [31:0] rec_count;
  logic        chain_over;

  result_t predicted_reports[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    failures++;
    if (failures <= 40)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'd0, d};
    for (int k = 0; k < 8; k++)
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    return r;
  endfunction

  task automatic queue_report(input logic valid, input logic done, input logic [2:0] reason,
                              input logic [31:0] offset, input logic [31:0] rbytes);
    result_t r;
    r.record_valid   = valid;
    r.chain_done     = done;
    r.record_tag     = valid ? rec_tag : 24'd0;
    r.data_length    = valid ? rec_len : 32'd0;
    r.record_offset  = valid ? offset : 32'd0;
    r.record_bytes   = valid ? rbytes : 32'd0;
    r.end_reason     = done ? reason : END_NO_ROOM;
    r.chain_complete = !(done && reason == END_OVERRUN);
    r.record_count   = rec_count;
    r.total_bytes    = rec_base;
    if (done)
      chain_over = 1'b1;
    predicted_reports.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic first);
    logic [31:0] rel;
    logic [31:0] offset;
    logic [63:0] span;
    logic [63:0] base64;
    logic [63:0] size64;
    if (first) begin
      cur_addr   = 32'd0;
      rec_base   = 32'd0;
      crc_acc    = CRC_INIT;
      crc_stored = 32'd0;
      rec_tag    = 24'd0;
      rec_len    = 32'd0;
      rec_count  = 32'd0;
      chain_over = 1'b0;
      if (dev_size == 32'd0) begin
        queue_report(1'b0, 1'b1, END_EMPTY, 32'd0, 32'd0);
        return;
      end
      if (dev_size < HEADER_BYTES) begin
        queue_report(1'b0, 1'b1, END_NO_ROOM, 32'd0, 32'd0);
        return;
      end
    end else if (chain_over) begin
      return;
    end

    rel = cur_addr - rec_base;
    cur_addr = cur_addr + 32'd1;
    // the stored CRC field counts as zero in the checksum
    crc_acc = crc_next(crc_acc, (rel >= POS_CRC_FIRST && rel < POS_LEN_FIRST) ? 8'h00 : b);

    if (rel == POS_FLAG) begin
      rec_tag    = 24'd0;
      crc_stored = 32'd0;
      rec_len    = 32'd0;
      if (b != FLAG_BYTE)
        queue_report(1'b0, 1'b1, END_NO_FLAG, 32'd0, 32'd0);
      return;
    end
    if (rel < POS_CRC_FIRST) begin
      rec_tag = {rec_tag[15:0], b};
      return;
    end
    if (rel < POS_LEN_FIRST) begin
      crc_stored = {crc_stored[23:0], b};
      return;
    end
    if (rel <= POS_LEN_LAST)
      rec_len = {rec_len[23:0], b};
    if (rel < POS_LEN_LAST)
      return;

    base64 = {32'd0, rec_base};
    size64 = {32'd0, dev_size};
    span = 64'd12 + (({32'd0, rec_len} + ALIGN - 1) / ALIGN) * ALIGN;
    if (rel == POS_LEN_LAST) begin
      if (rec_len > MAX_DATA_LEN) begin
        queue_report(1'b0, 1'b1, END_LEN_BIG, 32'd0, 32'd0);
        return;
      end
      if (base64 + 64'd12 + {32'd0, rec_len} > size64 || base64 + span > size64) begin
        queue_report(1'b0, 1'b1, END_OVERRUN, 32'd0, 32'd0);
        return;
      end
    end
    if ({32'd0, rel} + 64'd1 != span)
      return;

    if ((crc_acc ^ CRC_INIT) != crc_stored) begin
      queue_report(1'b0, 1'b1, END_CRC_BAD, 32'd0, 32'd0);
      return;
    end

    offset    = rec_base;
    rec_base  = rec_base + span[31:0];
    rec_count = rec_count + 32'd1;
    crc_acc   = CRC_INIT;
    // next record start must leave a full header before the device end
    queue_report(1'b1, {32'd0, rec_base} + 64'd12 > size64, END_NO_ROOM, offset, span[31:0]);
  endtask

  task automatic check_result();
    result_t want;
    if (predicted_reports.size() == 0) begin
      report("result with none pending", {30'd0, m_tlast, m_tuser}, 32'd0);
      return;
    end
    want = predicted_reports.pop_front();
    if (want.record_valid)
      records_seen++;
    if (want.chain_done)
      chain_ends++;
    if (m_tuser !== want.record_valid)
      report("record_valid", m_tuser, want.record_valid);
    if (m_tlast !== want.chain_done)
      report("chain_done", m_tlast, want.chain_done);
    if (m_tdata[23:0] !== want.record_tag)
      report("record_tag", m_tdata[23:0], want.record_tag);
    if (m_tdata[55:24] !== want.data_length)
      report("data_length", m_tdata[55:24], want.data_length);
    if (m_tdata[87:56] !== want.record_offset)
      report("record_offset", m_tdata[87:56], want.record_offset);
    if (m_tdata[119:88] !== want.record_bytes)
      report("record_bytes", m_tdata[119:88], want.record_bytes);
    if (m_tdata[122:120] !== want.end_reason)
      report("end_reason", m_tdata[122:120], want.end_reason);
    if (m_tdata[123] !== want.chain_complete)
      report("chain_complete", m_tdata[123], want.chain_complete);
    if (m_tdata[155:124] !== want.record_count)
      report("record_count", m_tdata[155:124], want.record_count);
    if (m_tdata[187:156] !== want.total_bytes)
      report("total_bytes", m_tdata[187:156], want.total_bytes);
    if (m_tdata[191:188] !== 4'd0)
      report("tdata fill bits", m_tdata[191:188], 32'd0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dev_size     = DEVICE_SIZE_RESET;
      cur_addr     = 32'd0;
      rec_base     = 32'd0;
      crc_acc      = CRC_INIT;
      crc_stored   = 32'd0;
      rec_tag      = 24'd0;
      rec_len      = 32'd0;
      rec_count    = 32'd0;
      chain_over   = 1'b1;
      failures     = 0;
      records_seen = 0;
      chain_ends   = 0;
      predicted_reports.delete();
    end else begin
      if (psel && penable && pready && paddr == ADDR_DEVICE_SIZE) begin
        if (pwrite)
          dev_size = pwdata;
        else if (prdata !== dev_size)
          report("prdata", prdata, dev_size);
      end
      if (s_tvalid && s_tready)
        parse_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready)
        check_result();
    end
    outstanding = predicted_reports.size();
  end

endmodule

// File: test/crc_checked_record_chain_parser_test.sv
// Top of the record chain parser testbench: clock, reset, byte stimulus and register
// writes. Depends on crcrp_pkg, the parser RTL and record_chain_checker.
`timescale 1ns / 100ps

module crc_checked_record_chain_parser_test;
  import crcrp_pkg::*;

  localparam int          ITEMS_TARGET = 1300;
  localparam int          SETTLE       = 6;
  localparam int unsigned LIMIT        = 400000;

  typedef enum int {
    KIND_GOOD,
    KIND_NO_FLAG,
    KIND_BAD_CRC,
    KIND_OVERRUN,
    KIND_TOO_LONG,
    KIND_CUT
  } rec_kind_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  logic [7:0]            s_tdata = 8'd0;   // data_byte[7:0]
  logic                  s_tuser = 1'b0;   // first_byte
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  // record_tag[23:0], data_length[55:24], record_offset[87:56], record_bytes[119:88],
  // end_reason[122:120], chain_complete[123], record_count[155:124], total_bytes[187:156]
  wire [TDATA_W-1:0]     m_tdata;
  wire                   m_tlast;          // chain_done
  wire                   m_tuser;          // record_valid
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = 32'd0;
  wire  [31:0]           prdata;
  wire                   pready;

  int failures;
  int outstanding;
  int records_seen;
  int chain_ends;

  logic [7:0]  image[$];    // device contents for the current chain
  logic [31:0] dev_bytes;   // device size currently programmed
  int          live_bytes;
  int          items;
  int          chains;
  bit          tx_calm;
  bit          rx_calm;
  int          stall_left;
  int unsigned cycle_count = 0;

  crc_checked_record_chain_parser #(.RECORD_ALIGN(4)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  record_chain_checker #(.ALIGN(4)) chain_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .failures(failures), .outstanding(outstanding),
    .records_seen(records_seen), .chain_ends(chain_ends)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_calm || $urandom_range(0, 99) < 65) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  function automatic logic [31:0] image_crc(input int unsigned from);
    logic [31:0] c;
    c = CRC_INIT;
    for (int unsigned i = from; i < image.size(); i++) begin
      c = c ^ {24'd0, image[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

  // header with CRC over header and body; body bytes (payload plus pad) are random
  task automatic put_record(input logic [23:0] tag, input logic [31:0] len,
                            input int unsigned body, input bit crc_bad);
    int unsigned base;
    logic [31:0] crc;
    logic [7:0]  d;
    base = image.size();
    image.push_back(FLAG_BYTE);
    image.push_back(tag[23:16]);
    image.push_back(tag[15:8]);
    image.push_back(tag[7:0]);
    repeat (4) image.push_back(8'h00);
    image.push_back(len[31:24]);
    image.push_back(len[23:16]);
    image.push_back(len[15:8]);
    image.push_back(len[7:0]);
    repeat (body) begin
      d = $urandom_range(0, 255);
      image.push_back(d);
    end
    crc = image_crc(base);
    if (crc_bad)
      crc = crc ^ (32'd1 << $urandom_range(0, 31));
    image[base + 4] = crc[31:24];
    image[base + 5] = crc[23:16];
    image[base + 6] = crc[15:8];
    image[base + 7] = crc[7:0];
  endtask

  // drop valid and wait until every predicted report has come out
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_device_size(input logic [31:0] value);
    quiesce();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_DEVICE_SIZE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // write lands here; read back follows without releasing psel
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    dev_bytes = value;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first, input bit hold);
    int unsigned gap;
    int unsigned pick;
    if (hold)
      quiesce();
    pick = $urandom_range(0, 99);
    gap = (tx_calm || pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_image(input bit with_hold);
    int hold_at;
    hold_at = with_hold ? $urandom_range(0, image.size() - 1) : -1;
    for (int i = 0; i < image.size(); i++)
      send_byte(image[i], i == 0, i == hold_at);
  endtask

  // one chain of records sized for the programmed device, mostly well formed
  task automatic build_chain();
    longint unsigned pos;
    longint unsigned room;
    longint unsigned lenmax;
    longint unsigned span;
    logic [31:0]     len;
    logic [23:0]     tag;
    logic [7:0]      junk;
    int unsigned     pick;
    int unsigned     n_rec;
    int unsigned     max_rec;
    bit              open;
    rec_kind_e       kind;
    image.delete();
    open = 1'b0;
    if (dev_bytes < HEADER_BYTES) begin
      junk = $urandom_range(0, 255);
      image.push_back(junk);
    end else begin
      pos = 0;
      n_rec = 0;
      max_rec = $urandom_range(1, 10);
      forever begin
        if ({32'd0, dev_bytes} - pos < 64'd12)
          break;
        room   = {32'd0, dev_bytes} - pos - 64'd12;
        lenmax = (room > 40) ? 64'd40 : (room & ~64'd3);
        pick   = $urandom_range(0, 99);
        kind   = (n_rec == max_rec) ? KIND_CUT :
                 (pick < 72) ? KIND_GOOD :
                 (pick < 78) ? KIND_NO_FLAG :
                 (pick < 84) ? KIND_BAD_CRC :
                 (pick < 90) ? KIND_OVERRUN :
                 (pick < 95) ? KIND_TOO_LONG : KIND_CUT;
        len  = (room <= 40 && $urandom_range(0, 1) == 1) ? lenmax[31:0] :
               $urandom_range(0, lenmax[31:0]);
        span = 64'd12 + (({32'd0, len} + 64'd3) & ~64'd3);
        tag  = $urandom_range(0, 24'hFFFFFF);
        case (kind)
          KIND_GOOD: begin
            put_record(tag, len, span - 12, 1'b0);
            pos = pos + span;
            n_rec++;
          end
          KIND_BAD_CRC: begin
            put_record(tag, len, span - 12, 1'b1);
            break;
          end
          KIND_CUT: begin
            // restart arrives in the middle of a record
            put_record(tag, len, span - 12, 1'b0);
            repeat ($urandom_range(1, span - 1)) image.pop_back();
            open = 1'b1;
            break;
          end
          KIND_NO_FLAG: begin
            junk = $urandom_range(0, 255);
            image.push_back(junk == FLAG_BYTE ? 8'h00 : junk);
            break;
          end
          KIND_OVERRUN: begin
            // just past the end, or fits unpadded but not padded
            lenmax = (room & ~64'd3) + $urandom_range(1, 8);
            put_record(tag, (lenmax > 64'hFFFFFFFF) ? MAX_DATA_LEN : lenmax[31:0], 0, 1'b0);
            break;
          end
          default: begin
            put_record(tag, ($urandom_range(0, 3) == 0) ? MAX_DATA_LEN :
                       $urandom_range(32'hFFFFFFFF, 32'hFFFF0001), 0, 1'b0);
            break;
          end
        endcase
      end
    end
    live_bytes = image.size();
    // bytes after the chain has ended are ignored
    if (!open) begin
      repeat ($urandom_range(0, 3)) begin
        junk = $urandom_range(0, 255);
        image.push_back(junk);
      end
    end
  endtask

  initial begin
    logic [31:0] size_plan [12];
    int phase;
    size_plan = '{32'd256, 32'd300, 32'd102, 32'd13, 32'd0, 32'd1000, 32'd12, 32'd64,
                  32'hFFFFFFFF, 32'd11, 32'd510, 32'hFFFFFFF0};
    dev_bytes = DEVICE_SIZE_RESET;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    items = 0;
    chains = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: byte before any restart, single record filling a 12-byte device,
    // empty device, device too small, oversize length, missing flag
    send_byte(8'hFF, 1'b0, 1'b0);
    set_device_size(32'd12);
    image.delete();
    put_record(24'hFFFFFF, 32'd0, 0, 1'b0);
    send_image(1'b0);
    set_device_size(32'd0);
    image.delete();
    image.push_back(FLAG_BYTE);
    send_image(1'b0);
    set_device_size(32'd11);
    image.delete();
    image.push_back(8'h00);
    send_image(1'b0);
    set_device_size(32'd256);
    image.delete();
    put_record(24'h000000, 32'hFFFFFFFF, 0, 1'b0);
    send_image(1'b0);
    image.delete();
    image.push_back(8'h3E);
    send_image(1'b0);
    items = 27;

    phase = 0;
    while (items < ITEMS_TARGET) begin
      if (phase < 12)
        set_device_size(size_plan[phase]);
      else if ($urandom_range(0, 4) == 0)
        set_device_size(size_plan[$urandom_range(0, 11)]);
      else
        set_device_size($urandom_range(12, 700));
      repeat ($urandom_range(2, 5)) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        build_chain();
        send_image(chains % 5 == 1);
        items += live_bytes;
        chains++;
      end
      phase++;
    end

    quiesce();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d device bytes in %0d chains over %0d size settings.", items, chains,
             phase + 4);
    $display("Checked %0d accepted records and %0d chain ends.", records_seen, chain_ends);
    if (failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
